// ===== sv/madc_pkg.sv =====
// Shared constants, types and the microcode ROM for the moving-average DC remover.
// No dependencies; imported by moving_average_dc_remover and the testbench.
package madc_pkg;

  // Sizes
  localparam int MAX_WINDOW  = 256;
  localparam int SAMPLE_W    = 16;
  localparam int OUT_W       = 17;
  localparam int WIN_W       = 9;
  localparam int POS_W       = $clog2(MAX_WINDOW);
  localparam int SUM_W       = 24;
  localparam int DIV_STEPS   = SUM_W;
  localparam int CNT_W       = $clog2(DIV_STEPS);
  localparam int DIVISOR_W   = POS_W + 1;
  localparam int PADDR_W     = 2;
  localparam int PDATA_W     = 32;
  localparam int WIN_RESET   = 256;
  localparam int PC_W        = 3;

  // Register byte addresses
  localparam logic [PADDR_W-1:0] REG_WINDOW_LENGTH = 2'd0;

  // Datapath operations
  typedef enum logic [2:0] {
    OP_WAIT,
    OP_SETUP,
    OP_DIV,
    OP_FINISH,
    OP_EMIT
  } op_e;

  // Jump conditions
  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN_ACC,
    COND_WIN_ZERO,
    COND_DIV_DONE,
    COND_OUT_FREE
  } cond_e;

  // One control word: op, jump condition, target, hold when condition false
  typedef struct packed {
    op_e             op;
    cond_e           cond;
    logic [PC_W-1:0] target;
    logic            hold;
  } uc_word_t;

  // Program step addresses
  localparam logic [PC_W-1:0] PC_WAIT   = 3'd0;
  localparam logic [PC_W-1:0] PC_SETUP  = 3'd1;
  localparam logic [PC_W-1:0] PC_DIV    = 3'd2;
  localparam logic [PC_W-1:0] PC_FINISH = 3'd3;
  localparam logic [PC_W-1:0] PC_EMIT   = 3'd4;

  // Microcode ROM
  function automatic uc_word_t uc_rom(input logic [PC_W-1:0] pc);
    uc_word_t w;
    case (pc)
      PC_WAIT:   w = '{op: OP_WAIT,   cond: COND_IN_ACC,   target: PC_SETUP,  hold: 1'b1};
      PC_SETUP:  w = '{op: OP_SETUP,  cond: COND_WIN_ZERO, target: PC_EMIT,   hold: 1'b0};
      PC_DIV:    w = '{op: OP_DIV,    cond: COND_DIV_DONE, target: PC_FINISH, hold: 1'b1};
      PC_FINISH: w = '{op: OP_FINISH, cond: COND_ALWAYS,   target: PC_EMIT,   hold: 1'b0};
      PC_EMIT:   w = '{op: OP_EMIT,   cond: COND_OUT_FREE, target: PC_WAIT,   hold: 1'b1};
      default:   w = '{op: OP_WAIT,   cond: COND_ALWAYS,   target: PC_WAIT,   hold: 1'b0};
    endcase
    return w;
  endfunction

endpackage

// ===== sv/moving_average_dc_remover.sv =====
// Moving-average DC remover: microcoded sequencer over a ring buffer and a
// bit-serial signed divider. Depends on madc_pkg.
// Each word passes WAIT, SETUP, the 24-step restoring divider, FINISH and
// EMIT; pass-through skips from SETUP to EMIT. New words are taken in WAIT.
// A finished word waits in the output register while the next word is taken.
// Reset: async active low; empty ring, window_length 256, no clearing pass.
module moving_average_dc_remover
  import madc_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] sample_in_i,
  // output channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [OUT_W-1:0]    sample_out_o,
  // config port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [PADDR_W-1:0]         paddr,
  input  logic [PDATA_W-1:0]         pwdata,
  output logic [PDATA_W-1:0]         prdata,
  output logic                       pready
);

  // Control and ring state
  logic [PC_W-1:0]      pc_q, pc_d;
  logic [WIN_W-1:0]     win_len_q;
  logic [POS_W-1:0]     wpos_q;
  logic                 full_q;
  logic [SUM_W-1:0]     sum_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 out_valid_q;

  // Payload registers
  logic signed [SAMPLE_W-1:0] samp_q;
  logic [SAMPLE_W-1:0]        rd_q;
  logic [SUM_W-1:0]           quo_q;
  logic [DIVISOR_W:0]         rem_q;
  logic [DIVISOR_W-1:0]       dsor_q;
  logic                       neg_q;
  logic [OUT_W-1:0]           res_q;
  logic [OUT_W-1:0]           out_data_q;

  logic [SAMPLE_W-1:0] hist_mem [MAX_WINDOW];

  uc_word_t uw;
  logic     in_acc, out_free, cond_hit, cfg_wr;
  logic [WIN_W-1:0]     win_eff;
  logic [DIVISOR_W-1:0] divisor;
  logic [SUM_W-1:0]     sum_abs;
  logic [DIVISOR_W:0]   rem_sh;
  logic                 q_bit;
  logic [DIVISOR_W:0]   rem_nx;
  logic [SUM_W:0]       mean_s;
  logic [SUM_W:0]       diff;
  logic [WIN_W-1:0]     wpos_inc;
  logic [SUM_W-1:0]     sum_upd;

  assign uw       = uc_rom(pc_q);
  assign in_stall_o = (pc_q != PC_WAIT);
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign cfg_wr   = psel && penable && pwrite && pready && (paddr == REG_WINDOW_LENGTH);

  // APB read and ready
  assign pready = 1'b1;
  assign prdata = (paddr == REG_WINDOW_LENGTH) ? {{(PDATA_W-WIN_W){1'b0}}, win_len_q} : '0;

  // Effective window and divisor
  assign win_eff = (win_len_q > WIN_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : win_len_q;
  always_comb begin
    if (full_q) begin
      divisor = DIVISOR_W'(win_eff);
    end else if (wpos_q == '0) begin
      divisor = DIVISOR_W'(1);
    end else begin
      divisor = {1'b0, wpos_q};
    end
  end
  assign sum_abs = sum_q[SUM_W-1] ? (~sum_q + SUM_W'(1)) : sum_q;

  // Restoring divide step
  assign rem_sh = {rem_q[DIVISOR_W-1:0], quo_q[SUM_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, dsor_q});
  assign rem_nx = q_bit ? (rem_sh - {1'b0, dsor_q}) : rem_sh;

  // Result: sample minus signed mean
  assign mean_s = neg_q ? (~{1'b0, quo_q} + (SUM_W+1)'(1)) : {1'b0, quo_q};
  assign diff   = {{(SUM_W+1-SAMPLE_W){samp_q[SAMPLE_W-1]}}, samp_q} - mean_s;

  // Ring update values
  assign wpos_inc = {1'b0, wpos_q} + WIN_W'(1);
  assign sum_upd  = sum_q + {{(SUM_W-SAMPLE_W){samp_q[SAMPLE_W-1]}}, samp_q}
                  - (full_q ? {{(SUM_W-SAMPLE_W){rd_q[SAMPLE_W-1]}}, rd_q} : SUM_W'(0));

  // Sequencer next step
  always_comb begin
    case (uw.cond)
      COND_ALWAYS:   cond_hit = 1'b1;
      COND_IN_ACC:   cond_hit = in_acc;
      COND_WIN_ZERO: cond_hit = (win_eff == '0);
      COND_DIV_DONE: cond_hit = (cnt_q == CNT_W'(DIV_STEPS-1));
      COND_OUT_FREE: cond_hit = out_free;
      default:       cond_hit = 1'b1;
    endcase
    if (cond_hit) begin
      pc_d = uw.target;
    end else if (uw.hold) begin
      pc_d = pc_q;
    end else begin
      pc_d = pc_q + PC_W'(1);
    end
  end

  // Control state, ring pointers and running sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= PC_WAIT;
      win_len_q   <= WIN_W'(WIN_RESET);
      wpos_q      <= '0;
      full_q      <= 1'b0;
      sum_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      if (cfg_wr) begin
        win_len_q <= pwdata[WIN_W-1:0];
        wpos_q    <= '0;
        full_q    <= 1'b0;
        sum_q     <= '0;
      end
      case (uw.op)
        OP_SETUP: cnt_q <= '0;
        OP_DIV:   cnt_q <= cnt_q + CNT_W'(1);
        OP_FINISH: begin
          if ({1'b0, wpos_q} < win_eff) begin
            sum_q <= sum_upd;
            if (wpos_inc >= win_eff) begin
              wpos_q <= '0;
              full_q <= 1'b1;
            end else begin
              wpos_q <= wpos_inc[POS_W-1:0];
            end
          end else begin
            wpos_q <= '0;
            full_q <= 1'b0;
            sum_q  <= '0;
          end
        end
        default: ;
      endcase
      // output register handshake
      if (uw.op == OP_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath payload and history memory
  always_ff @(posedge clk_i) begin
    case (uw.op)
      OP_WAIT: begin
        if (in_acc) begin
          samp_q <= sample_in_i;
          rd_q   <= hist_mem[wpos_q];
        end
      end
      OP_SETUP: begin
        quo_q  <= sum_abs;
        rem_q  <= '0;
        dsor_q <= divisor;
        neg_q  <= sum_q[SUM_W-1];
        res_q  <= OUT_W'(samp_q);
      end
      OP_DIV: begin
        rem_q <= rem_nx;
        quo_q <= {quo_q[SUM_W-2:0], q_bit};
      end
      OP_FINISH: begin
        res_q <= diff[OUT_W-1:0];
        if ({1'b0, wpos_q} < win_eff) begin
          hist_mem[wpos_q] <= samp_q;
        end
      end
      OP_EMIT: begin
        if (out_free) begin
          out_data_q <= res_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_data_q;

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for moving_average_dc_remover: APB window setup,
// random-gap sample stream, mean-removal predictor and output scoreboard.
// Depends on madc_pkg and the moving_average_dc_remover RTL.
module testbench;
  import madc_pkg::*;

  localparam int LIMIT_CYCLES = 400_000;
  localparam int DRAIN_CYCLES = 60;

  // Predicts sample minus truncated window mean, keeps the words in flight
  class dc_tracker;
    logic [WIN_W-1:0]           win_len;
    logic signed [SAMPLE_W-1:0] ring [MAX_WINDOW];
    int unsigned                wr_pos;
    bit                         filled;
    longint                     acc;
    logic signed [OUT_W-1:0]    pending_out [$];
    int unsigned                fails;

    function new();
      win_len = WIN_W'(WIN_RESET);
      fails   = 0;
      clear_ring();
    endfunction

    function void clear_ring();
      wr_pos = 0;
      filled = 1'b0;
      acc    = 0;
    endfunction

    // a window write also empties the ring
    function void set_window(logic [PDATA_W-1:0] value);
      win_len = value[WIN_W-1:0];
      clear_ring();
    endfunction

    function void take_sample(logic signed [SAMPLE_W-1:0] s);
      int unsigned span;
      longint      divisor;
      longint      mean;
      longint      diff;
      span = (win_len > MAX_WINDOW) ? MAX_WINDOW : win_len;
      if (span == 0) begin
        diff = longint'(s);
      end else begin
        // divide by the fill count until the ring has wrapped once
        divisor = longint'(filled ? span : ((wr_pos == 0) ? 1 : wr_pos));
        mean    = acc / divisor;
        diff    = longint'(s) - mean;
        if (wr_pos < span) begin
          if (filled) acc -= longint'(ring[wr_pos]);
          ring[wr_pos] = s;
          acc += longint'(s);
          wr_pos++;
          if (wr_pos >= span) begin
            wr_pos = 0;
            filled = 1'b1;
          end
        end else begin
          clear_ring();
        end
      end
      pending_out.push_back(diff[OUT_W-1:0]);
    endfunction

    function void check_output(logic signed [OUT_W-1:0] got);
      logic signed [OUT_W-1:0] want;
      if (pending_out.size() == 0) begin
        $display("%0t: unexpected sample_out word, expected none, actual %0d", $time, got);
        fails++;
      end else begin
        want = pending_out.pop_front();
        if (got !== want) begin
          $display("%0t: sample_out mismatch, expected %0d, actual %0d", $time, want, got);
          fails++;
        end
      end
    endfunction
  endclass

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_stall_o;
  logic signed [SAMPLE_W-1:0] sample_in_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic signed [OUT_W-1:0]    sample_out_o;
  logic                       psel        = 1'b0;
  logic                       penable     = 1'b0;
  logic                       pwrite      = 1'b0;
  logic [PADDR_W-1:0]         paddr       = '0;
  logic [PDATA_W-1:0]         pwdata      = '0;
  logic [PDATA_W-1:0]         prdata;
  logic                       pready;

  dc_tracker   trk = new();
  bit          steady = 1'b0;
  int unsigned cycles = 0;

  moving_average_dc_remover u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_o (sample_out_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // output side: random stall, no stall during a steady phase
  always @(negedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(99) < 7);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) trk.check_output(sample_out_o);
  end

  // APB write: setup then access, register taken at the pready edge
  task automatic write_window(input logic [PDATA_W-1:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = REG_WINDOW_LENGTH;
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    trk.set_window(value);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic read_window();
    logic [PDATA_W-1:0] want;
    want    = PDATA_W'(trk.win_len);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = REG_WINDOW_LENGTH;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) begin
      $display("%0t: window_length readback mismatch, expected %0d, actual %0d",
               $time, want, prdata);
      trk.fails++;
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // one input word; called and left at a falling edge
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
    while (!steady && ($urandom_range(99) < 7)) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    sample_in_i = s;
    do @(posedge clk_i); while (in_stall_o);
    trk.take_sample(s);
    @(negedge clk_i);
  endtask

  // block is idle once every predicted word has come out
  task automatic drain();
    while (trk.pending_out.size() != 0) @(negedge clk_i);
  endtask

  task automatic reconfigure(input logic [PDATA_W-1:0] value);
    in_valid_i = 1'b0;
    drain();
    write_window(value);
    read_window();
  endtask

  // a DC level with noise most often, else full-range words or rail values
  function automatic logic signed [SAMPLE_W-1:0] pick_sample(
      input logic signed [SAMPLE_W-1:0] offset);
    int unsigned                r;
    logic signed [SAMPLE_W-1:0] noise;
    r = $urandom_range(99);
    noise = SAMPLE_W'($urandom_range(511));
    if (r < 40) return SAMPLE_W'($urandom);
    if (r < 85) return offset + noise - 16'sd256;
    if (r < 92) return 16'sh7FFF;
    return 16'sh8000;
  endfunction

  task automatic run_window(input logic [PDATA_W-1:0] value, input int n, input bit quiet);
    logic signed [SAMPLE_W-1:0] offset;
    offset = SAMPLE_W'($urandom);
    reconfigure(value);
    steady = quiet;
    repeat (n) send_sample(pick_sample(offset));
    in_valid_i = 1'b0;
    steady = 1'b0;
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset window, empty ring first, then rails and bit patterns
    read_window();
    send_sample(16'sh0000);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(-16'sd1);
    send_sample(16'sd1);
    send_sample(16'sh5555);
    send_sample(16'shAAAA);

    // pass-through
    reconfigure(32'd0);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh1234);

    // window of one gives the output extremes
    reconfigure(32'd1);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);

    // upper data bits ignored: window of three, wraps twice
    reconfigure(32'hFFFF_FE03);
    send_sample(16'sd100);
    send_sample(-16'sd200);
    send_sample(16'sd300);
    send_sample(16'sd7);
    send_sample(-16'sd7);
    send_sample(16'sd5);

    // above the maximum acts as the maximum
    reconfigure(32'd300);
    send_sample(16'sh7FFF);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh0001);

    // full ring of negative rail drives the sum to its floor
    reconfigure(32'd256);
    repeat (260) send_sample(16'sh8000);
    repeat (20) send_sample(16'sh7FFF);
    in_valid_i = 1'b0;

    run_window(32'd256, 300, 1'b0);
    run_window(32'd511, 300, 1'b1);
    run_window(32'd1, 60, 1'b0);
    run_window(32'd2, 60, 1'b0);
    run_window(32'd0, 60, 1'b0);
    run_window(32'd7, 100, 1'b0);
    run_window(PDATA_W'($urandom_range(40, 3)), 120, 1'b0);
    run_window(PDATA_W'($urandom_range(511, 0)), 150, 1'b0);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (trk.fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
